// File: src/sat_pkg.sv
// shared constants, codes and types for the two-shape separating axis overlap test
// no dependencies; imported by every module under src
package sat_pkg;

  localparam int MAX_VERTICES = 16;
  localparam int MAX_AXES     = 16;

  // index and count widths of the per-shape lists
  localparam int VIW = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
  localparam int AIW = (MAX_AXES > 1) ? $clog2(MAX_AXES) : 1;
  localparam int VCW = $clog2(MAX_VERTICES + 1);
  localparam int ACW = $clog2(MAX_AXES + 1);

  // store depth: both shapes side by side, shape select is the address msb
  localparam int VDEPTH = 2 * (1 << VIW);
  localparam int ADEPTH = 2 * (1 << AIW);

  localparam int CW = 32;  // Q16.16 coordinate
  localparam int RW = 31;  // radius
  localparam int OW = 33;  // multiplier operand
  localparam int PW = 66;  // full product
  localparam int SW = 67;  // sum of two products

  typedef enum logic [2:0] {
    OP_VERTEX = 3'd0,
    OP_AXIS   = 3'd1,
    OP_POS    = 3'd2,
    OP_CIRCLE = 3'd3,
    OP_EVAL   = 3'd4
  } sat_op_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_OVF   = 2'd1,
    ST_EMPTY = 2'd2
  } sat_status_e;

  // loaded scene, held stable while an evaluate runs
  typedef struct packed {
    logic [1:0][VCW-1:0] vcnt;
    logic [1:0][ACW-1:0] acnt;
    logic [1:0][CW-1:0]  pos_x;
    logic [1:0][CW-1:0]  pos_y;
    logic [1:0][CW-1:0]  cen_x;
    logic [1:0][CW-1:0]  cen_y;
    logic [1:0][RW-1:0]  rad;
    logic [1:0]          circ;
    logic                ovf;
  } sat_ctx_t;

  typedef struct packed {
    logic        colliding;
    sat_status_e status;
  } sat_res_t;

  function automatic logic signed [OW-1:0] sext_op(input logic [CW-1:0] v);
    return {v[CW-1], v};
  endfunction

endpackage

// File: src/sat_polygon_overlap_test_top.sv
// load items are accepted back to back; input stalls only while an evaluate runs
// evaluate: both circles by a squared distance test, empty polygon or no axes straight to the verdict,
//   otherwise per axis every vertex of shape 0 and then of shape 1 on the one shared multiplier;
//   the verdict is registered in the output register; the next item is taken once it is handed off
// reset clears counts, flags, positions, circles and handshake state; the stores are not cleared
// depends on sat_pkg, sat_store, sat_eval (and sat_mul through it)
module sat_polygon_overlap_test_top import sat_pkg::*; (
  input  logic          clk_i,
  input  logic          rst_ni,
  // input channel
  input  logic          in_valid_i,
  output logic          in_stall_o,
  input  logic [2:0]    op_i,
  input  logic          shape_sel_i,
  input  logic [CW-1:0] coord_x_i,
  input  logic [CW-1:0] coord_y_i,
  input  logic [RW-1:0] radius_i,
  // result channel
  output logic          out_valid_o,
  input  logic          out_stall_i,
  output logic          colliding_o,
  output logic [1:0]    status_o
);

  // scene registers
  logic [1:0][VCW-1:0] vcnt_q;
  logic [1:0][ACW-1:0] acnt_q;
  logic [1:0][CW-1:0]  pos_x_q, pos_y_q;
  logic [1:0][CW-1:0]  cen_x_q, cen_y_q;
  logic [1:0][RW-1:0]  rad_q;
  logic [1:0]          circ_q;
  logic                ovf_q;

  // handshake and output register
  logic                busy_q;
  logic                out_valid_q;
  logic                colliding_q;
  sat_status_e         status_q;

  logic                accept;
  logic                v_room, a_room;
  logic                v_we, a_we;
  logic                handoff, out_free;
  logic [VIW:0]        v_raddr;
  logic [AIW:0]        a_raddr;
  logic [2*CW-1:0]     v_rdata, a_rdata;
  logic                res_valid;
  sat_res_t            res;
  sat_ctx_t            ctx;

  assign in_stall_o = busy_q;
  assign accept     = in_valid_i && !busy_q;

  // a full list drops the transaction and raises the overflow flag
  assign v_room = vcnt_q[shape_sel_i] != VCW'(MAX_VERTICES);
  assign a_room = acnt_q[shape_sel_i] != ACW'(MAX_AXES);
  assign v_we   = accept && (op_i == OP_VERTEX) && v_room;
  assign a_we   = accept && (op_i == OP_AXIS) && a_room;

  // output register frees up this cycle or is already empty
  assign out_free = !out_valid_q || !out_stall_i;
  assign handoff  = res_valid && out_free;

  sat_store u_store (
    .clk_i     (clk_i),
    .v_we_i    (v_we),
    .v_waddr_i ({shape_sel_i, vcnt_q[shape_sel_i][VIW-1:0]}),
    .v_wdata_i ({coord_x_i, coord_y_i}),
    .v_raddr_i (v_raddr),
    .v_rdata_o (v_rdata),
    .a_we_i    (a_we),
    .a_waddr_i ({shape_sel_i, acnt_q[shape_sel_i][AIW-1:0]}),
    .a_wdata_i ({coord_x_i, coord_y_i}),
    .a_raddr_i (a_raddr),
    .a_rdata_o (a_rdata)
  );

  assign ctx.vcnt  = vcnt_q;
  assign ctx.acnt  = acnt_q;
  assign ctx.pos_x = pos_x_q;
  assign ctx.pos_y = pos_y_q;
  assign ctx.cen_x = cen_x_q;
  assign ctx.cen_y = cen_y_q;
  assign ctx.rad   = rad_q;
  assign ctx.circ  = circ_q;
  assign ctx.ovf   = ovf_q;

  sat_eval u_eval (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (accept && (op_i == OP_EVAL)),
    .ctx_i       (ctx),
    .v_raddr_o   (v_raddr),
    .v_rdata_i   (v_rdata),
    .a_raddr_o   (a_raddr),
    .a_rdata_i   (a_rdata),
    .res_valid_o (res_valid),
    .res_o       (res),
    .res_ack_i   (out_free)
  );

  // load transactions; scene stays put while busy since input is stalled
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vcnt_q  <= '0;
      acnt_q  <= '0;
      pos_x_q <= '0;
      pos_y_q <= '0;
      cen_x_q <= '0;
      cen_y_q <= '0;
      rad_q   <= '0;
      circ_q  <= '0;
      ovf_q   <= 1'b0;
      busy_q  <= 1'b0;
    end else if (handoff) begin
      // every evaluate empties the lists
      vcnt_q <= '0;
      acnt_q <= '0;
      ovf_q  <= 1'b0;
      busy_q <= 1'b0;
    end else if (accept) begin
      case (op_i)
        OP_VERTEX: begin
          if (v_room) begin
            vcnt_q[shape_sel_i] <= vcnt_q[shape_sel_i] + VCW'(1);
          end else begin
            ovf_q <= 1'b1;
          end
        end
        OP_AXIS: begin
          if (a_room) begin
            acnt_q[shape_sel_i] <= acnt_q[shape_sel_i] + ACW'(1);
          end else begin
            ovf_q <= 1'b1;
          end
        end
        OP_POS: begin
          pos_x_q[shape_sel_i] <= coord_x_i;
          pos_y_q[shape_sel_i] <= coord_y_i;
        end
        OP_CIRCLE: begin
          // centers are world coordinates, position not applied
          cen_x_q[shape_sel_i] <= coord_x_i;
          cen_y_q[shape_sel_i] <= coord_y_i;
          rad_q[shape_sel_i]   <= radius_i;
          circ_q[shape_sel_i]  <= 1'b1;
        end
        OP_EVAL: begin
          busy_q <= 1'b1;
        end
        default: begin
          // unused op codes are taken and ignored
          busy_q <= 1'b0;
        end
      endcase
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (handoff) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (handoff) begin
      colliding_q <= res.colliding;
      status_q    <= res.status;
    end
  end

  assign out_valid_o = out_valid_q;
  assign colliding_o = colliding_q;
  assign status_o    = status_q;

endmodule

// File: src/sat_store.sv
// vertex and axis stores, one write and one registered read port each
// depends on sat_pkg
module sat_store import sat_pkg::*; (
  input  logic              clk_i,
  input  logic              v_we_i,
  input  logic [VIW:0]      v_waddr_i,
  input  logic [2*CW-1:0]   v_wdata_i,
  input  logic [VIW:0]      v_raddr_i,
  output logic [2*CW-1:0]   v_rdata_o,
  input  logic              a_we_i,
  input  logic [AIW:0]      a_waddr_i,
  input  logic [2*CW-1:0]   a_wdata_i,
  input  logic [AIW:0]      a_raddr_i,
  output logic [2*CW-1:0]   a_rdata_o
);

  logic [2*CW-1:0] vmem [VDEPTH];
  logic [2*CW-1:0] amem [ADEPTH];
  logic [2*CW-1:0] v_rdata_q;
  logic [2*CW-1:0] a_rdata_q;

  always_ff @(posedge clk_i) begin
    if (v_we_i) begin
      vmem[v_waddr_i] <= v_wdata_i;
    end
    v_rdata_q <= vmem[v_raddr_i];
  end

  always_ff @(posedge clk_i) begin
    if (a_we_i) begin
      amem[a_waddr_i] <= a_wdata_i;
    end
    a_rdata_q <= amem[a_raddr_i];
  end

  assign v_rdata_o = v_rdata_q;
  assign a_rdata_o = a_rdata_q;

endmodule

// File: src/sat_mul.sv
// shared 33x33 signed multiplier with registered full-width product
// depends on sat_pkg
module sat_mul import sat_pkg::*; (
  input  logic                 clk_i,
  input  logic                 en_i,
  input  logic signed [OW-1:0] a_i,
  input  logic signed [OW-1:0] b_i,
  output logic signed [PW-1:0] p_o
);

  logic signed [PW-1:0] p_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      p_q <= a_i * b_i;
    end
  end

  assign p_o = p_q;

endmodule

// File: src/sat_eval.sv
// evaluate sequencer: circle test or axis-by-vertex projection over the shared multiplier
// depends on sat_pkg, sat_mul
module sat_eval import sat_pkg::*; (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start_i,
  input  sat_ctx_t        ctx_i,
  output logic [VIW:0]    v_raddr_o,
  input  logic [2*CW-1:0] v_rdata_i,
  output logic [AIW:0]    a_raddr_o,
  input  logic [2*CW-1:0] a_rdata_i,
  output logic            res_valid_o,
  output sat_res_t        res_o,
  input  logic            res_ack_i
);

  typedef enum logic [15:0] {
    S_IDLE = 16'h0001,
    S_CD   = 16'h0002,
    S_CX   = 16'h0004,
    S_CY   = 16'h0008,
    S_CR   = 16'h0010,
    S_CC   = 16'h0020,
    S_ARD  = 16'h0040,
    S_ALD  = 16'h0080,
    S_VRD  = 16'h0100,
    S_VADD = 16'h0200,
    S_MX   = 16'h0400,
    S_MY   = 16'h0800,
    S_SUM  = 16'h1000,
    S_CMP  = 16'h2000,
    S_SEP  = 16'h4000,
    S_DONE = 16'h8000
  } sat_state_e;

  sat_state_e state_q, state_d;

  logic                 ash_q;
  logic [AIW-1:0]       ai_q;
  logic                 ps_q;
  logic [VIW-1:0]       vi_q;
  logic [CW-1:0]        ax_q, ay_q;
  logic signed [OW-1:0] wx_q, wy_q;
  logic [CW-1:0]        rs_q;
  logic signed [SW-1:0] acc_q;
  logic signed [SW-1:0] mn_q [2];
  logic signed [SW-1:0] mx_q [2];
  logic                 hit_q;
  sat_status_e          status_q;

  logic                 mul_en;
  logic signed [OW-1:0] mul_a, mul_b;
  logic signed [PW-1:0] prod;
  logic signed [SW-1:0] prod_x;
  logic                 both_circ, no_verts, no_axes;
  logic                 last_v, last_a, sep;
  sat_status_e          base_status;

  sat_mul u_mul (
    .clk_i (clk_i),
    .en_i  (mul_en),
    .a_i   (mul_a),
    .b_i   (mul_b),
    .p_o   (prod)
  );

  assign prod_x      = {prod[PW-1], prod};
  assign both_circ   = ctx_i.circ[0] && ctx_i.circ[1];
  assign no_verts    = (ctx_i.vcnt[0] == '0) || (ctx_i.vcnt[1] == '0);
  assign no_axes     = (ctx_i.acnt[0] == '0) && (ctx_i.acnt[1] == '0);
  assign base_status = ctx_i.ovf ? ST_OVF : ST_OK;
  assign last_v      = (VCW'(vi_q) + VCW'(1)) == ctx_i.vcnt[ps_q];
  assign last_a      = (ACW'(ai_q) + ACW'(1)) == ctx_i.acnt[ash_q];
  // touching intervals overlap
  assign sep         = !((mn_q[0] <= mx_q[1]) && (mn_q[1] <= mx_q[0]));

  // operand selection for the shared multiplier
  always_comb begin
    mul_en = 1'b0;
    mul_a  = wx_q;
    mul_b  = wx_q;
    case (state_q)
      S_CX: begin
        mul_en = 1'b1;
      end
      S_CY: begin
        mul_en = 1'b1;
        mul_a  = wy_q;
        mul_b  = wy_q;
      end
      S_CR: begin
        mul_en = 1'b1;
        mul_a  = {1'b0, rs_q};
        mul_b  = {1'b0, rs_q};
      end
      S_MX: begin
        mul_en = 1'b1;
        mul_b  = sext_op(ax_q);
      end
      S_MY: begin
        mul_en = 1'b1;
        mul_a  = wy_q;
        mul_b  = sext_op(ay_q);
      end
      default: begin
        mul_en = 1'b0;
      end
    endcase
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (start_i) begin
          if (both_circ) begin
            state_d = S_CD;
          end else if (no_verts || no_axes) begin
            state_d = S_DONE;
          end else begin
            state_d = S_ARD;
          end
        end
      end
      S_CD:   state_d = S_CX;
      S_CX:   state_d = S_CY;
      S_CY:   state_d = S_CR;
      S_CR:   state_d = S_CC;
      S_CC:   state_d = S_DONE;
      S_ARD:  state_d = S_ALD;
      S_ALD:  state_d = S_VRD;
      S_VRD:  state_d = S_VADD;
      S_VADD: state_d = S_MX;
      S_MX:   state_d = S_MY;
      S_MY:   state_d = S_SUM;
      S_SUM:  state_d = S_CMP;
      S_CMP: begin
        if (last_v && ps_q) begin
          state_d = S_SEP;
        end else begin
          state_d = S_VRD;
        end
      end
      S_SEP: begin
        if (sep) begin
          state_d = S_DONE;
        end else if (!last_a) begin
          state_d = S_ARD;
        end else if (!ash_q && (ctx_i.acnt[1] != '0)) begin
          state_d = S_ARD;
        end else begin
          state_d = S_DONE;
        end
      end
      S_DONE: begin
        if (res_ack_i) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      S_IDLE: begin
        status_q <= base_status;
        hit_q    <= 1'b1;
        ash_q    <= (ctx_i.acnt[0] == '0);
        ai_q     <= '0;
        if (!both_circ && no_verts) begin
          hit_q    <= 1'b0;
          status_q <= ST_EMPTY;
        end
      end
      S_CD: begin
        wx_q <= sext_op(ctx_i.cen_x[1]) - sext_op(ctx_i.cen_x[0]);
        wy_q <= sext_op(ctx_i.cen_y[1]) - sext_op(ctx_i.cen_y[0]);
        rs_q <= {1'b0, ctx_i.rad[0]} + {1'b0, ctx_i.rad[1]};
      end
      S_CY: begin
        acc_q <= prod_x;
      end
      S_CR: begin
        acc_q <= acc_q + prod_x;
      end
      S_CC: begin
        hit_q <= (acc_q <= prod_x);
      end
      S_ALD: begin
        ax_q <= a_rdata_i[2*CW-1:CW];
        ay_q <= a_rdata_i[CW-1:0];
        ps_q <= 1'b0;
        vi_q <= '0;
      end
      S_VADD: begin
        // world vertex = local vertex + shape position
        wx_q <= sext_op(v_rdata_i[2*CW-1:CW]) + sext_op(ctx_i.pos_x[ps_q]);
        wy_q <= sext_op(v_rdata_i[CW-1:0]) + sext_op(ctx_i.pos_y[ps_q]);
      end
      S_MY: begin
        acc_q <= prod_x;
      end
      S_SUM: begin
        acc_q <= acc_q + prod_x;
      end
      S_CMP: begin
        if ((vi_q == '0) || (acc_q < mn_q[ps_q])) begin
          mn_q[ps_q] <= acc_q;
        end
        if ((vi_q == '0) || (acc_q > mx_q[ps_q])) begin
          mx_q[ps_q] <= acc_q;
        end
        if (last_v) begin
          ps_q <= 1'b1;
          vi_q <= '0;
        end else begin
          vi_q <= vi_q + VIW'(1);
        end
      end
      S_SEP: begin
        if (sep) begin
          hit_q <= 1'b0;
        end else if (!last_a) begin
          ai_q <= ai_q + AIW'(1);
        end else begin
          ash_q <= 1'b1;
          ai_q  <= '0;
        end
      end
      default: begin
        hit_q <= hit_q;
      end
    endcase
  end

  assign v_raddr_o        = {ps_q, vi_q};
  assign a_raddr_o        = {ash_q, ai_q};
  assign res_valid_o      = (state_q == S_DONE);
  assign res_o.colliding  = hit_q;
  assign res_o.status     = status_q;

endmodule

// File: tb/sv/sat_polygon_overlap_test_top_tb.sv
// self-checking testbench for the two-shape separating axis overlap test
// drives load and evaluate transactions, predicts every verdict and compares it
// depends on sat_pkg and sat_polygon_overlap_test_top
module sat_polygon_overlap_test_top_tb;
  import sat_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  // op codes that the block takes and ignores
  localparam logic [2:0] OP_UNUSED_LO = 3'd5;
  localparam logic [2:0] OP_UNUSED_HI = 3'd7;

  // handy Q16.16 values
  localparam logic [31:0] Q_ZERO = 32'h0000_0000;
  localparam logic [31:0] Q_ONE  = 32'h0001_0000;
  localparam logic [31:0] Q_TWO  = 32'h0002_0000;
  localparam logic [31:0] Q_MAX  = 32'h7fff_ffff;
  localparam logic [31:0] Q_MIN  = 32'h8000_0000;
  localparam logic [30:0] R_ZERO = 31'h0;
  localparam logic [30:0] R_ONE  = 31'h0001_0000;
  localparam logic [30:0] R_MAX  = 31'h7fff_ffff;

  // stimulus volume: polygon phase first, circle phase last (circle flags never clear)
  localparam int POLY_ITEMS  = 690;
  localparam int TOTAL_ITEMS = 800;
  localparam int DRAIN_LIMIT = 200000;
  localparam int TAIL_CYCLES = 64;

  logic          clk_i       = 1'b0;
  logic          rst_ni      = 1'b0;
  logic          in_valid_i  = 1'b0;
  logic          in_stall_o;
  logic [2:0]    op_i        = '0;
  logic          shape_sel_i = 1'b0;
  logic [CW-1:0] coord_x_i   = '0;
  logic [CW-1:0] coord_y_i   = '0;
  logic [RW-1:0] radius_i    = '0;
  logic          out_valid_o;
  logic          out_stall_i = 1'b0;
  logic          colliding_o;
  logic [1:0]    status_o;

  sat_polygon_overlap_test_top dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .op_i        (op_i),
    .shape_sel_i (shape_sel_i),
    .coord_x_i   (coord_x_i),
    .coord_y_i   (coord_y_i),
    .radius_i    (radius_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .colliding_o (colliding_o),
    .status_o    (status_o)
  );

  // 20 ns period
  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // scene model: our own copy of everything the loads build up
  // ---------------------------------------------------------------------------
  logic signed [31:0] vtx_x [2][MAX_VERTICES];
  logic signed [31:0] vtx_y [2][MAX_VERTICES];
  logic signed [31:0] nrm_x [2][MAX_AXES];
  logic signed [31:0] nrm_y [2][MAX_AXES];
  int unsigned        vtx_cnt  [2] = '{0, 0};
  int unsigned        nrm_cnt  [2] = '{0, 0};
  logic signed [31:0] pos_x    [2] = '{0, 0};
  logic signed [31:0] pos_y    [2] = '{0, 0};
  logic signed [31:0] cen_x    [2] = '{0, 0};
  logic signed [31:0] cen_y    [2] = '{0, 0};
  logic [30:0]        rad      [2] = '{0, 0};
  bit                 circ_set [2] = '{0, 0};
  bit                 list_ovf     = 1'b0;

  // verdicts still owed by the block, oldest first
  sat_res_t verdict_q [$];

  int  mismatch_count = 0;
  int  sent_items     = 0;
  int  verdicts_seen  = 0;
  int  hits_seen      = 0;
  int  ovf_seen       = 0;
  int  empty_seen     = 0;
  bit  in_calm        = 1'b0;

  // exact Q32.32 dot product of a world point with an axis
  function automatic logic signed [127:0] axis_dot(input longint wx, input longint wy,
                                                   input longint qx, input longint qy);
    logic signed [127:0] a, b, c, d;
    a = 128'(wx);
    b = 128'(qx);
    c = 128'(wy);
    d = 128'(qy);
    return a * b + c * d;
  endfunction

  // interval of one shape's world vertices on an axis (shape has at least one vertex)
  function automatic void project_shape(input int s, input longint qx, input longint qy,
                                        output logic signed [127:0] lo,
                                        output logic signed [127:0] hi);
    logic signed [127:0] d;
    longint wx, wy;
    lo = '0;
    hi = '0;
    for (int i = 0; i < int'(vtx_cnt[s]); i++) begin
      wx = longint'(vtx_x[s][i]) + longint'(pos_x[s]);
      wy = longint'(vtx_y[s][i]) + longint'(pos_y[s]);
      d  = axis_dot(wx, wy, qx, qy);
      if (i == 0 || d < lo) lo = d;
      if (i == 0 || d > hi) hi = d;
    end
  endfunction

  // touching intervals still count as overlap
  function automatic bit axis_separates(input logic signed [31:0] qx,
                                        input logic signed [31:0] qy);
    logic signed [127:0] lo0, hi0, lo1, hi1;
    project_shape(0, longint'(qx), longint'(qy), lo0, hi0);
    project_shape(1, longint'(qx), longint'(qy), lo1, hi1);
    return !(lo0 <= hi1 && lo1 <= hi0);
  endfunction

  // centers are world coordinates, position is not added
  function automatic bit circles_meet();
    logic signed [127:0] dx, dy, rs;
    dx = 128'(longint'(cen_x[1]) - longint'(cen_x[0]));
    dy = 128'(longint'(cen_y[1]) - longint'(cen_y[0]));
    rs = 128'(rad[0]) + 128'(rad[1]);
    return (dx * dx + dy * dy) <= rs * rs;
  endfunction

  function automatic sat_res_t judge_scene();
    sat_res_t v;
    bit hit;
    v.colliding = 1'b0;
    v.status    = list_ovf ? ST_OVF : ST_OK;
    if (circ_set[0] && circ_set[1]) begin
      // both circles: vertex and axis lists play no part
      v.colliding = circles_meet();
    end else if (vtx_cnt[0] == 0 || vtx_cnt[1] == 0) begin
      // empty polygon wins over overflow
      v.status = ST_EMPTY;
    end else begin
      // no axes at all leaves hit set
      hit = 1'b1;
      for (int s = 0; s < 2; s++)
        for (int i = 0; i < int'(nrm_cnt[s]); i++)
          if (hit && axis_separates(nrm_x[s][i], nrm_y[s][i])) hit = 1'b0;
      v.colliding = hit;
    end
    return v;
  endfunction

  // apply one accepted transaction to the scene, returns the verdict of an evaluate
  task automatic apply_item(input logic [2:0] op, input logic sel,
                            input logic signed [31:0] x, input logic signed [31:0] y,
                            input logic [30:0] r, output bit has_res, output sat_res_t res);
    has_res = 1'b0;
    res     = '0;
    case (op)
      OP_VERTEX: begin
        if (vtx_cnt[sel] < MAX_VERTICES) begin
          vtx_x[sel][vtx_cnt[sel]] = x;
          vtx_y[sel][vtx_cnt[sel]] = y;
          vtx_cnt[sel]++;
        end else begin
          list_ovf = 1'b1;
        end
      end
      OP_AXIS: begin
        if (nrm_cnt[sel] < MAX_AXES) begin
          nrm_x[sel][nrm_cnt[sel]] = x;
          nrm_y[sel][nrm_cnt[sel]] = y;
          nrm_cnt[sel]++;
        end else begin
          list_ovf = 1'b1;
        end
      end
      OP_POS: begin
        pos_x[sel] = x;
        pos_y[sel] = y;
      end
      OP_CIRCLE: begin
        cen_x[sel]    = x;
        cen_y[sel]    = y;
        rad[sel]      = r;
        circ_set[sel] = 1'b1;
      end
      OP_EVAL: begin
        res        = judge_scene();
        has_res    = 1'b1;
        vtx_cnt    = '{0, 0};
        nrm_cnt    = '{0, 0};
        list_ovf   = 1'b0;
      end
      default: ;
    endcase
  endtask

  // ---------------------------------------------------------------------------
  // random values
  // ---------------------------------------------------------------------------
  // input gap: mostly none or short, now and then long
  function automatic int pick_gap();
    int r;
    if (in_calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(4, 30);
  endfunction

  // coordinates: mostly a coarse grid near the origin so that touching happens
  function automatic logic [31:0] pick_coord();
    int r, k;
    r = $urandom_range(0, 99);
    if (r < 60) begin
      k = $urandom_range(0, 16);
      k -= 8;
      return k * 32768;
    end
    if (r < 85) begin
      k = $urandom_range(0, (1 << 25) - 1);
      return k - (1 << 24);
    end
    if (r < 95) return $urandom;
    case ($urandom_range(0, 3))
      0:       return Q_MIN;
      1:       return Q_MAX;
      2:       return Q_ZERO;
      default: return '1;
    endcase
  endfunction

  // axes: mostly small whole numbers, zero axis included
  function automatic logic [31:0] pick_axis();
    int k;
    if ($urandom_range(0, 99) >= 70) return pick_coord();
    k = $urandom_range(0, 4);
    k -= 2;
    return k * 65536;
  endfunction

  function automatic logic [30:0] pick_radius();
    if ($urandom_range(0, 99) < 60) return 31'($urandom_range(0, 32'h6_0000));
    return 31'($urandom);
  endfunction

  // ---------------------------------------------------------------------------
  // input side
  // ---------------------------------------------------------------------------
  // one transaction: optional gap, hold until accepted, then predict
  task automatic send_item(input logic [2:0] op, input logic sel,
                           input logic [31:0] x, input logic [31:0] y, input logic [30:0] r,
                           input bit typed, input logic want_hit, input sat_status_e want_st);
    int gap;
    bit has_res;
    sat_res_t pred;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i  <= 1'b1;
    op_i        <= op;
    shape_sel_i <= sel;
    coord_x_i   <= x;
    coord_y_i   <= y;
    radius_i    <= r;
    do @(posedge clk_i); while (in_stall_o !== 1'b0);
    apply_item(op, sel, x, y, r, has_res, pred);
    if (has_res) begin
      // directed rows with an obvious answer carry it themselves
      if (typed) begin
        pred.colliding = want_hit;
        pred.status    = want_st;
      end
      verdict_q = {verdict_q, pred};
    end
    if (op <= OP_EVAL) sent_items++;
  endtask

  // ignored op codes, or a circle on shape 0 (harmless until shape 1 has one too)
  task automatic send_noise(input bit poly_phase);
    if (poly_phase && $urandom_range(0, 2) == 0)
      send_item(OP_CIRCLE, 1'b0, pick_coord(), pick_coord(), pick_radius(), 1'b0, 1'b0,
                ST_OK);
    else
      send_item(3'($urandom_range(OP_UNUSED_LO, OP_UNUSED_HI)), 1'($urandom), $urandom,
                $urandom, 31'($urandom), 1'b0, 1'b0, ST_OK);
  endtask

  // one polygon pair: shuffled vertex and axis loads, sometimes too many or none
  task automatic send_polygon_pair();
    int left [4];
    int mode, k, total;
    in_calm = ($urandom_range(0, 4) == 0);
    // order: vertices shape 0, vertices shape 1, axes shape 0, axes shape 1
    left[0] = $urandom_range(1, 5);
    left[1] = $urandom_range(1, 5);
    left[2] = $urandom_range(0, 3);
    left[3] = $urandom_range(0, 3);
    mode = $urandom_range(0, 99);
    if (mode < 8) begin
      k = $urandom_range(0, 3);
      left[k] = ((k < 2) ? MAX_VERTICES : MAX_AXES) + $urandom_range(1, 2);
    end else if (mode < 14) begin
      left[$urandom_range(0, 1)] = 0;
    end
    for (int s = 0; s < 2; s++)
      if ($urandom_range(0, 2) == 0)
        send_item(OP_POS, s[0], pick_coord(), pick_coord(), 31'($urandom), 1'b0, 1'b0,
                  ST_OK);
    total = left[0] + left[1] + left[2] + left[3];
    while (total > 0) begin
      do k = $urandom_range(0, 3); while (left[k] == 0);
      left[k]--;
      total--;
      if ($urandom_range(0, 19) == 0) send_noise(1'b1);
      if (k < 2)
        send_item(OP_VERTEX, k[0], pick_coord(), pick_coord(), 31'($urandom), 1'b0, 1'b0,
                  ST_OK);
      else
        send_item(OP_AXIS, k[0], pick_axis(), pick_axis(), 31'($urandom), 1'b0, 1'b0,
                  ST_OK);
    end
    send_item(OP_EVAL, 1'($urandom), $urandom, $urandom, 31'($urandom), 1'b0, 1'b0, ST_OK);
  endtask

  // circle phase: new circles, a few ignored vertex, axis and position loads, sometimes an overflow
  task automatic send_circle_pair();
    int n;
    in_calm = ($urandom_range(0, 4) == 0);
    for (int s = 0; s < 2; s++)
      if ($urandom_range(0, 2) != 0)
        send_item(OP_CIRCLE, s[0], pick_coord(), pick_coord(), pick_radius(), 1'b0, 1'b0,
                  ST_OK);
    n = ($urandom_range(0, 9) == 0) ? MAX_VERTICES + $urandom_range(1, 2) : $urandom_range(0, 3);
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 19) == 0) send_noise(1'b0);
      send_item((n > MAX_VERTICES) ? OP_VERTEX : 3'($urandom_range(OP_VERTEX, OP_POS)),
                (n > MAX_VERTICES) ? 1'b0 : 1'($urandom), pick_coord(), pick_coord(),
                31'($urandom), 1'b0, 1'b0, ST_OK);
    end
    send_item(OP_EVAL, 1'($urandom), $urandom, $urandom, 31'($urandom), 1'b0, 1'b0, ST_OK);
  endtask

  // ---------------------------------------------------------------------------
  // directed table: polygon rows first, circle rows from CIRCLE_ROW on
  // ---------------------------------------------------------------------------
  typedef struct packed {
    logic [2:0]  op;
    logic        sel;
    logic [31:0] x;
    logic [31:0] y;
    logic [30:0] r;
    int          rep;
    bit          typed;
    logic        hit;
    sat_status_e st;
  } stim_row_t;

  localparam int DIR_ROWS   = 17;
  localparam int CIRCLE_ROW = 11;

  stim_row_t dir_rows [DIR_ROWS] = '{
    // nothing loaded after reset
    '{OP_EVAL,      1'b0, Q_ZERO, Q_ZERO, R_ZERO,  1, 1'b1, 1'b0, ST_EMPTY},
    // ignored op codes with extreme payloads
    '{OP_UNUSED_LO, 1'b1, Q_MIN,  Q_MAX,  R_MAX,   1, 1'b0, 1'b0, ST_OK},
    '{OP_UNUSED_HI, 1'b0, Q_MAX,  Q_MIN,  R_ZERO,  1, 1'b0, 1'b0, ST_OK},
    // shape 1 sits two units to the right
    '{OP_POS,       1'b1, Q_TWO,  Q_ZERO, R_ZERO,  1, 1'b0, 1'b0, ST_OK},
    // one vertex too many for shape 0
    '{OP_VERTEX,    1'b0, Q_ZERO, Q_ZERO, R_ZERO, 17, 1'b0, 1'b0, ST_OK},
    '{OP_VERTEX,    1'b1, Q_ZERO, Q_ZERO, R_ZERO,  1, 1'b0, 1'b0, ST_OK},
    '{OP_AXIS,      1'b0, Q_ONE,  Q_ZERO, R_ZERO,  1, 1'b0, 1'b0, ST_OK},
    // x axis splits the points, overflow still reported
    '{OP_EVAL,      1'b0, Q_ZERO, Q_ZERO, R_ZERO,  1, 1'b1, 1'b0, ST_OVF},
    // extreme vertices but no axes: always colliding
    '{OP_VERTEX,    1'b0, Q_MAX,  Q_MIN,  R_ZERO,  1, 1'b0, 1'b0, ST_OK},
    '{OP_VERTEX,    1'b1, Q_MIN,  Q_MAX,  R_ZERO,  1, 1'b0, 1'b0, ST_OK},
    '{OP_EVAL,      1'b1, Q_ZERO, Q_ZERO, R_ZERO,  1, 1'b1, 1'b1, ST_OK},
    // unit circles two apart just touch
    '{OP_CIRCLE,    1'b0, Q_ZERO, Q_ZERO, R_ONE,   1, 1'b0, 1'b0, ST_OK},
    '{OP_CIRCLE,    1'b1, Q_TWO,  Q_ZERO, R_ONE,   1, 1'b0, 1'b0, ST_OK},
    '{OP_EVAL,      1'b0, Q_ZERO, Q_ZERO, R_ZERO,  1, 1'b1, 1'b1, ST_OK},
    // opposite corners with the largest radii
    '{OP_CIRCLE,    1'b1, Q_MAX,  Q_MIN,  R_MAX,   1, 1'b0, 1'b0, ST_OK},
    '{OP_CIRCLE,    1'b0, Q_MIN,  Q_MAX,  R_MAX,   1, 1'b0, 1'b0, ST_OK},
    '{OP_EVAL,      1'b0, Q_ZERO, Q_ZERO, R_ZERO,  1, 1'b1, 1'b0, ST_OK}
  };

  task automatic run_rows(input int first, input int last);
    in_calm = 1'b0;
    for (int i = first; i < last; i++)
      repeat (dir_rows[i].rep)
        send_item(dir_rows[i].op, dir_rows[i].sel, dir_rows[i].x, dir_rows[i].y,
                  dir_rows[i].r, dir_rows[i].typed, dir_rows[i].hit, dir_rows[i].st);
  endtask

  // ---------------------------------------------------------------------------
  // result side: random stall, checker
  // ---------------------------------------------------------------------------
  // stall in bursts: short ones mostly, a few long, and quiet stretches with none
  initial begin : result_stall
    int r;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    forever begin
      r = $urandom_range(0, 99);
      if (r < 15) begin
        out_stall_i <= 1'b0;
        repeat ($urandom_range(20, 80)) @(posedge clk_i);
      end else begin
        out_stall_i <= 1'b1;
        repeat ((r < 90) ? $urandom_range(1, 3) : $urandom_range(4, 40)) @(posedge clk_i);
        out_stall_i <= 1'b0;
        repeat ($urandom_range(1, 6)) @(posedge clk_i);
      end
    end
  end

  // every handed-off verdict against the oldest one owed
  always @(posedge clk_i) begin : result_check
    sat_res_t want;
    if (rst_ni === 1'b1 && out_valid_o === 1'b1 && out_stall_i === 1'b0) begin
      if (verdict_q.size() == 0) begin
        $display("%0t: verdict colliding=%0b status=%0d with no transaction pending",
                 $time, colliding_o, status_o);
        mismatch_count++;
      end else begin
        want = verdict_q.pop_front();
        verdicts_seen++;
        if (colliding_o !== want.colliding) begin
          $display("%0t: colliding mismatch, expected %0b actual %0b",
                   $time, want.colliding, colliding_o);
          mismatch_count++;
        end
        if (status_o !== want.status) begin
          $display("%0t: status mismatch, expected %0d actual %0d",
                   $time, want.status, status_o);
          mismatch_count++;
        end
        if (want.colliding) hits_seen++;
        if (want.status == ST_OVF) ovf_seen++;
        if (want.status == ST_EMPTY) empty_seen++;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // main sequence
  // ---------------------------------------------------------------------------
  initial begin : main_seq
    int waited;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // polygons first: once both shapes have a circle the circle test is all that is left
    run_rows(0, CIRCLE_ROW);
    while (sent_items < POLY_ITEMS) send_polygon_pair();
    run_rows(CIRCLE_ROW, DIR_ROWS);
    while (sent_items < TOTAL_ITEMS) send_circle_pair();
    in_valid_i <= 1'b0;

    // drain, then watch a while for anything extra
    waited = 0;
    while (verdict_q.size() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk_i);
      waited++;
    end
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (verdict_q.size() != 0) begin
      $display("%0t: %0d verdicts never arrived", $time, verdict_q.size());
      mismatch_count++;
    end

    $display("sent %0d load and evaluate transactions, checked %0d verdicts",
             sent_items, verdicts_seen);
    $display("verdicts: %0d colliding, %0d with list overflow, %0d with an empty polygon",
             hits_seen, ovf_seen, empty_seen);
    if (mismatch_count == 0)
      $display("CHECK OK");
    else
      $display("CHECK FAILED");
    $finish;
  end

  // hard stop, far beyond the slowest legal run
  initial begin : watchdog
    #20_000_000;
    $display("%0t: timeout", $time);
    $display("CHECK FAILED");
    $finish;
  end

endmodule
